@@ hdl/dpf_pkg.sv @@
// shared constants, codes and cell data types for the disk potential force pipeline
`default_nettype none
package dpf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int XW = 32;
	localparam int STAT_W = 2;
	localparam int CFG_IW = 2;
	localparam int IN_W = 3 * XW;
	localparam int OUT_W = ((4 * XW + STAT_W + 7) / 8) * 8;

	localparam int SQ_N = 34;
	localparam int ROOT_W = SQ_N;
	localparam int RAD_W = 2 * SQ_N;
	localparam int SREM_W = SQ_N + 2;

	localparam int CH_W = 34;
	localparam int P_W = XW + 1;
	localparam int D_W = 2 * P_W + 1;
	localparam int DEN_W = D_W + ROOT_W;
	localparam int DENW_W = DEN_W + XW;
	localparam int DREM_W = DENW_W + 1;
	localparam int GZP_W = 2 * XW + P_W;
	localparam int N_W = GZP_W + 2 * FRAC_BITS;
	localparam int Q_W = XW;

	localparam int DEPTH = 2 + SQ_N + 3 + SQ_N + 5 + Q_W + 1;

	localparam logic [CFG_IW-1:0] REG_MASS = 2'd0;
	localparam logic [CFG_IW-1:0] REG_SCALE_A = 2'd1;
	localparam logic [CFG_IW-1:0] REG_SCALE_B_SQ = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
	localparam logic [STAT_W-1:0] ST_SING = 2'd2;

	localparam logic [XW-1:0] ONE_Q = XW'(1) << FRAC_BITS;

	typedef struct packed {
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0] rad;
	} sq_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [DENW_W-1:0] dv;
		logic [Q_W-1:0] lo;
		logic [Q_W-1:0] quo;
	} dv_t;

endpackage
`default_nettype wire

@@ hdl/dpf_sqrt_cell.sv @@
// one bit of a digit-by-digit integer square root
`default_nettype none
module dpf_sqrt_cell (
	input wire logic clk,
	input wire logic en,
	input wire dpf_pkg::sq_t arg,
	output dpf_pkg::sq_t res_q
);

	logic [dpf_pkg::SREM_W-1:0] rs;
	logic [dpf_pkg::SREM_W-1:0] tr;
	logic [dpf_pkg::SREM_W-1:0] df;
	logic ge;

	assign rs = {arg.rem[dpf_pkg::SREM_W-3:0], arg.rad[dpf_pkg::RAD_W-1 -: 2]};
	assign tr = {arg.root, 2'b01};
	assign ge = rs >= tr;
	assign df = rs - tr;

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.rem <= ge ? df : rs;
			res_q.root <= {arg.root[dpf_pkg::ROOT_W-2:0], ge};
			res_q.rad <= {arg.rad[dpf_pkg::RAD_W-3:0], 2'b00};
		end
	end

endmodule
`default_nettype wire

@@ hdl/dpf_div_cell.sv @@
// one quotient bit of a restoring divider
`default_nettype none
module dpf_div_cell (
	input wire logic clk,
	input wire logic en,
	input wire dpf_pkg::dv_t arg,
	output dpf_pkg::dv_t res_q
);

	logic [dpf_pkg::DREM_W-1:0] rs;
	logic [dpf_pkg::DREM_W-1:0] dext;
	logic [dpf_pkg::DREM_W-1:0] df;
	logic ge;

	assign rs = {arg.rem[dpf_pkg::DREM_W-2:0], arg.lo[dpf_pkg::Q_W-1]};
	assign dext = {1'b0, arg.dv};
	assign ge = rs >= dext;
	assign df = rs - dext;

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.rem <= ge ? df : rs;
			res_q.dv <= arg.dv;
			res_q.lo <= {arg.lo[dpf_pkg::Q_W-2:0], 1'b0};
			res_q.quo <= {arg.quo[dpf_pkg::Q_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

@@ hdl/disk_potential_force_eval.sv @@
// Takes one position per clock and returns one force/potential result per clock while the
// output is not stalled. The pipeline is built from two rows of 34 square-root cells and
// four parallel rows of 32 divider cells, each cell resolving one bit, plus multiply stages.
// The whole pipeline advances whenever the output register is empty or being taken, so a
// stalled output stalls all items in flight. Configuration takes effect immediately and
// should be written only while no item is in flight.
`default_nettype none
module disk_potential_force_eval (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [dpf_pkg::IN_W-1:0] s_axis_tdata, // pos_x, pos_y, pos_z
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [dpf_pkg::OUT_W-1:0] m_axis_tdata, // force_x, force_y, force_z, potential, status
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [dpf_pkg::CFG_IW-1:0] cfg_index,
	input wire logic [dpf_pkg::XW-1:0] cfg_data
);

	localparam int XW = dpf_pkg::XW;
	localparam int SQ_N = dpf_pkg::SQ_N;
	localparam int Q_W = dpf_pkg::Q_W;
	localparam int CH_W = dpf_pkg::CH_W;
	localparam int P_W = dpf_pkg::P_W;
	localparam int D_W = dpf_pkg::D_W;
	localparam int DEN_W = dpf_pkg::DEN_W;
	localparam int DENW_W = dpf_pkg::DENW_W;
	localparam int DREM_W = dpf_pkg::DREM_W;
	localparam int GZP_W = dpf_pkg::GZP_W;
	localparam int N_W = dpf_pkg::N_W;
	localparam int RAD_W = dpf_pkg::RAD_W;
	localparam int DEPTH = dpf_pkg::DEPTH;
	localparam int LN_X = 0;
	localparam int LN_Y = 1;
	localparam int LN_Z = 2;
	localparam int LN_P = 3;

	typedef struct packed {
		logic [XW-1:0] ax;
		logic [XW-1:0] ay;
		logic [XW-1:0] az;
		logic [2:0] ps;
		logic [2*XW-1:0] ax2;
		logic [2*XW-1:0] ay2;
	} side1_t;

	typedef struct packed {
		logic [XW-1:0] ax;
		logic [XW-1:0] ay;
		logic [XW-1:0] az;
		logic [2:0] ps;
		logic [XW-1:0] w;
		logic [P_W-1:0] p;
		logic [D_W-1:0] d;
	} side2_t;

	typedef struct packed {
		logic [2:0] ps;
		logic [3:0] pre;
		logic wz;
		logic sz;
	} side3_t;

	function automatic logic [XW:0] emit(input logic neg, input logic pre,
		input logic [Q_W-1:0] quo);
		logic [XW-1:0] lim;
		logic sat;
		logic [XW-1:0] val;
		lim = neg ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
		sat = pre || (quo > lim);
		val = sat ? lim : quo;
		if (neg) begin
			val = -val;
		end
		return {sat, val};
	endfunction

	logic adv;
	logic [DEPTH-1:0] vld_q;
	logic [XW-1:0] mass_q;
	logic [XW-1:0] scale_a_q;
	logic [XW-1:0] scale_b_sq_q;

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = vld_q[DEPTH-1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= dpf_pkg::ONE_Q;
			scale_a_q <= dpf_pkg::ONE_Q;
			scale_b_sq_q <= dpf_pkg::ONE_Q;
		end else if (cfg_valid) begin
			case (cfg_index)
				dpf_pkg::REG_MASS: mass_q <= cfg_data;
				dpf_pkg::REG_SCALE_A: scale_a_q <= cfg_data;
				dpf_pkg::REG_SCALE_B_SQ: scale_b_sq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	// stage 1: magnitudes and signs
	logic [XW-1:0] px, py, pz;
	logic [XW-1:0] ax_s1, ay_s1, az_s1;
	logic [2:0] ps_s1;

	assign px = s_axis_tdata[XW-1:0];
	assign py = s_axis_tdata[2*XW-1:XW];
	assign pz = s_axis_tdata[3*XW-1:2*XW];

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= px[XW-1] ? (~px + XW'(1)) : px;
			ay_s1 <= py[XW-1] ? (~py + XW'(1)) : py;
			az_s1 <= pz[XW-1] ? (~pz + XW'(1)) : pz;
			ps_s1 <= {!pz[XW-1] && (pz != '0), !py[XW-1] && (py != '0),
				!px[XW-1] && (px != '0)};
		end
	end

	// stage 2: squares and radicand of w
	logic [2*XW-1:0] ax2_c, ay2_c, az2_c;
	logic [RAD_W-1:0] t_s2;
	side1_t sd_s2;

	assign ax2_c = ax_s1 * ax_s1;
	assign ay2_c = ay_s1 * ay_s1;
	assign az2_c = az_s1 * az_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2 <= (RAD_W'(scale_b_sq_q) << dpf_pkg::FRAC_BITS) + RAD_W'(az2_c);
			sd_s2 <= '{ax: ax_s1, ay: ay_s1, az: az_s1, ps: ps_s1, ax2: ax2_c, ay2: ay2_c};
		end
	end

	// square root row for w
	dpf_pkg::sq_t sq1 [SQ_N+1];
	side1_t sd1_q [SQ_N];

	assign sq1[0] = '{rem: '0, root: '0, rad: t_s2};

	for (genvar k = 0; k < SQ_N; k++) begin : g_sq1
		dpf_sqrt_cell u_cell (.clk(clk), .en(adv), .arg(sq1[k]), .res_q(sq1[k+1]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd1_q[0] <= sd_s2;
			for (int k = 1; k < SQ_N; k++) begin
				sd1_q[k] <= sd1_q[k-1];
			end
		end
	end

	// stages 3 to 5: p, p squared, d
	logic [P_W-1:0] p_s3, p_s4;
	logic [XW-1:0] w_s3, w_s4;
	side1_t sd_s3, sd_s4;
	logic [2*P_W-1:0] pp_c, pp_s4;
	side2_t sd2_s5;

	assign pp_c = p_s3 * p_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3 <= P_W'(scale_a_q) + P_W'(sq1[SQ_N].root[XW-1:0]);
			w_s3 <= sq1[SQ_N].root[XW-1:0];
			sd_s3 <= sd1_q[SQ_N-1];
			pp_s4 <= pp_c;
			p_s4 <= p_s3;
			w_s4 <= w_s3;
			sd_s4 <= sd_s3;
			sd2_s5 <= '{ax: sd_s4.ax, ay: sd_s4.ay, az: sd_s4.az, ps: sd_s4.ps, w: w_s4,
				p: p_s4, d: D_W'(pp_s4) + D_W'(sd_s4.ax2) + D_W'(sd_s4.ay2)};
		end
	end

	// square root row for s
	dpf_pkg::sq_t sq2 [SQ_N+1];
	side2_t sd2_q [SQ_N];

	assign sq2[0] = '{rem: '0, root: '0, rad: RAD_W'(sd2_s5.d)};

	for (genvar k = 0; k < SQ_N; k++) begin : g_sq2
		dpf_sqrt_cell u_cell (.clk(clk), .en(adv), .arg(sq2[k]), .res_q(sq2[k+1]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd2_q[0] <= sd2_s5;
			for (int k = 1; k < SQ_N; k++) begin
				sd2_q[k] <= sd2_q[k-1];
			end
		end
	end

	// stages 6 to 9: denominators and numerators
	side2_t sd2e;
	logic [dpf_pkg::ROOT_W-1:0] s_e;
	logic [2*CH_W-1:0] dp0_c, dp0_s6;
	logic [D_W-CH_W+CH_W-1:0] dp1_c, dp1_s6;
	logic [2*XW-1:0] gmx_c, gmy_c, gmz_c;
	logic [2*XW-1:0] gmx_s6, gmy_s6, gmz_s6, gmx_s7, gmy_s7, gmx_s8, gmy_s8, gmx_s9, gmy_s9;
	logic [dpf_pkg::ROOT_W-1:0] s_s6, s_s7, s_s8, s_s9;
	logic [XW-1:0] w_s6, w_s7, w_s8, w_s9;
	logic [P_W-1:0] p_s6;
	logic [2:0] ps_s6, ps_s7, ps_s8, ps_s9;
	logic [DEN_W-1:0] den_s7, den_s8, den_s9;
	logic [CH_W+P_W-1:0] zp0_c, zp0_s7;
	logic [2*XW-CH_W+P_W-1:0] zp1_c, zp1_s7;
	logic [GZP_W-1:0] gmzp_s8, gmzp_s9;
	logic [CH_W+XW-1:0] wp0_c, wp1_c, wp0_s8, wp1_s8;
	logic [DEN_W-2*CH_W+XW-1:0] wp2_c, wp2_s8;
	logic [DENW_W-1:0] denw_s9;

	assign sd2e = sd2_q[SQ_N-1];
	assign s_e = sq2[SQ_N].root;
	assign dp0_c = sd2e.d[CH_W-1:0] * s_e;
	assign dp1_c = sd2e.d[D_W-1:CH_W] * s_e;
	assign gmx_c = mass_q * sd2e.ax;
	assign gmy_c = mass_q * sd2e.ay;
	assign gmz_c = mass_q * sd2e.az;
	assign zp0_c = gmz_s6[CH_W-1:0] * p_s6;
	assign zp1_c = gmz_s6[2*XW-1:CH_W] * p_s6;
	assign wp0_c = den_s7[CH_W-1:0] * w_s7;
	assign wp1_c = den_s7[2*CH_W-1:CH_W] * w_s7;
	assign wp2_c = den_s7[DEN_W-1:2*CH_W] * w_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			dp0_s6 <= dp0_c;
			dp1_s6 <= dp1_c;
			gmx_s6 <= gmx_c;
			gmy_s6 <= gmy_c;
			gmz_s6 <= gmz_c;
			s_s6 <= s_e;
			w_s6 <= sd2e.w;
			p_s6 <= sd2e.p;
			ps_s6 <= sd2e.ps;

			den_s7 <= DEN_W'(dp0_s6) + (DEN_W'(dp1_s6) << CH_W);
			zp0_s7 <= zp0_c;
			zp1_s7 <= zp1_c;
			gmx_s7 <= gmx_s6;
			gmy_s7 <= gmy_s6;
			s_s7 <= s_s6;
			w_s7 <= w_s6;
			ps_s7 <= ps_s6;

			gmzp_s8 <= GZP_W'(zp0_s7) + (GZP_W'(zp1_s7) << CH_W);
			wp0_s8 <= wp0_c;
			wp1_s8 <= wp1_c;
			wp2_s8 <= wp2_c;
			den_s8 <= den_s7;
			gmx_s8 <= gmx_s7;
			gmy_s8 <= gmy_s7;
			s_s8 <= s_s7;
			w_s8 <= w_s7;
			ps_s8 <= ps_s7;

			// even partial products do not overlap, odd one added on top
			denw_s9 <= DENW_W'({wp2_s8, 2'b00, wp0_s8}) + (DENW_W'(wp1_s8) << CH_W);
			den_s9 <= den_s8;
			gmzp_s9 <= gmzp_s8;
			gmx_s9 <= gmx_s8;
			gmy_s9 <= gmy_s8;
			s_s9 <= s_s8;
			w_s9 <= w_s8;
			ps_s9 <= ps_s8;
		end
	end

	// stage 10: divider setup and overflow precheck
	logic [N_W-1:0] nx_c, ny_c, nz_c, np_c;
	logic [DREM_W-1:0] hx_c, hy_c, hz_c, hp_c;
	logic [DENW_W-1:0] dx_c, dz_c, dpt_c;
	dpf_pkg::dv_t dch [4][Q_W+1];
	dpf_pkg::dv_t di_s10 [4];
	side3_t sd3_s10;
	side3_t sd3_q [Q_W];

	assign nx_c = N_W'(gmx_s9) << (2 * dpf_pkg::FRAC_BITS);
	assign ny_c = N_W'(gmy_s9) << (2 * dpf_pkg::FRAC_BITS);
	assign nz_c = N_W'(gmzp_s9) << (2 * dpf_pkg::FRAC_BITS);
	assign np_c = N_W'(mass_q) << dpf_pkg::FRAC_BITS;
	assign hx_c = DREM_W'(nx_c[N_W-1:Q_W]);
	assign hy_c = DREM_W'(ny_c[N_W-1:Q_W]);
	assign hz_c = DREM_W'(nz_c[N_W-1:Q_W]);
	assign hp_c = DREM_W'(np_c[N_W-1:Q_W]);
	assign dx_c = DENW_W'(den_s9);
	assign dz_c = denw_s9;
	assign dpt_c = DENW_W'(s_s9);

	always_ff @(posedge clk) begin
		if (adv) begin
			di_s10[LN_X] <= '{rem: hx_c, dv: dx_c, lo: nx_c[Q_W-1:0], quo: '0};
			di_s10[LN_Y] <= '{rem: hy_c, dv: dx_c, lo: ny_c[Q_W-1:0], quo: '0};
			di_s10[LN_Z] <= '{rem: hz_c, dv: dz_c, lo: nz_c[Q_W-1:0], quo: '0};
			di_s10[LN_P] <= '{rem: hp_c, dv: dpt_c, lo: np_c[Q_W-1:0], quo: '0};
			sd3_s10 <= '{ps: ps_s9,
				pre: {hp_c >= DREM_W'(dpt_c), hz_c >= DREM_W'(dz_c),
					hy_c >= DREM_W'(dx_c), hx_c >= DREM_W'(dx_c)},
				wz: w_s9 == '0, sz: s_s9 == '0};
		end
	end

	// divider rows
	for (genvar j = 0; j < 4; j++) begin : g_lane
		assign dch[j][0] = di_s10[j];
		for (genvar k = 0; k < Q_W; k++) begin : g_div
			dpf_div_cell u_cell (.clk(clk), .en(adv), .arg(dch[j][k]), .res_q(dch[j][k+1]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd3_q[0] <= sd3_s10;
			for (int k = 1; k < Q_W; k++) begin
				sd3_q[k] <= sd3_q[k-1];
			end
		end
	end

	// output stage: sign, saturation, status
	side3_t sd3e;
	logic [XW:0] ex, ey, ez, ep;
	logic sat_c;
	logic [XW-1:0] fx_c, fy_c, fz_c, pot_c;
	logic [dpf_pkg::STAT_W-1:0] st_c;
	logic [dpf_pkg::OUT_W-1:0] out_q;

	assign sd3e = sd3_q[Q_W-1];
	assign ex = emit(sd3e.ps[0], sd3e.pre[LN_X], dch[LN_X][Q_W].quo);
	assign ey = emit(sd3e.ps[1], sd3e.pre[LN_Y], dch[LN_Y][Q_W].quo);
	assign ez = emit(sd3e.ps[2], sd3e.pre[LN_Z], dch[LN_Z][Q_W].quo);
	assign ep = emit(1'b1, sd3e.pre[LN_P], dch[LN_P][Q_W].quo);

	always_comb begin
		sat_c = ex[XW] || ey[XW] || (!sd3e.wz && ez[XW]) || ep[XW];
		fx_c = ex[XW-1:0];
		fy_c = ey[XW-1:0];
		fz_c = sd3e.wz ? '0 : ez[XW-1:0];
		pot_c = ep[XW-1:0];
		if (sd3e.wz) begin
			st_c = dpf_pkg::ST_SING;
		end else if (sat_c) begin
			st_c = dpf_pkg::ST_SAT;
		end else begin
			st_c = dpf_pkg::ST_OK;
		end
		if (sd3e.sz) begin
			fx_c = '0;
			fy_c = '0;
			fz_c = '0;
			pot_c = '0;
			st_c = dpf_pkg::ST_SING;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= dpf_pkg::OUT_W'({st_c, pot_c, fz_c, fy_c, fx_c});
		end
	end

	assign m_axis_tdata = out_q;

	// singular results carry no z force
	a_sing_fz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[4*XW+1:4*XW] == dpf_pkg::ST_SING)
		|-> m_axis_tdata[3*XW-1:2*XW] == '0)
		else $error("singular result with nonzero force_z");

	// potential is never positive
	a_pot_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[4*XW-1] || (m_axis_tdata[4*XW-1:3*XW] == '0))
		else $error("positive potential");

	// an item accepted while the pipeline is empty is registered in the first valid stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && vld_q[DEPTH-2:0] == '0 && m_axis_tready
		|=> vld_q[0])
		else $error("accepted item lost at pipeline entry");

endmodule
`default_nettype wire
